### rtl/core/htd_pkg.sv
// Package for the Huffman tree decoder: operation, character and status codes,
// fixed byte values, parameter defaults and the sequencer state type.
// Used by huffman_tree_decoder; depends on nothing.
package htd_pkg;

  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int NODE_COUNT_DEF   = 512;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [1:0] KIND_ZERO    = 2'd0;
  localparam logic [1:0] KIND_ONE     = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;
  localparam logic [1:0] KIND_OTHER   = 2'd3;

  localparam logic [1:0] ST_SYMBOL   = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] FILL_SYMBOL  = 8'd42;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_D_EV,
    S_D_LF,
    S_L1_RD,
    S_L1_EV,
    S_L2_RD,
    S_L2_EV,
    S_L2_NEW
  } state_t;

endpackage

### rtl/core/huffman_tree_decoder.sv
// Bit-serial Huffman decoder over a code tree held in a node store with one read port and one write port.
// Depends on htd_pkg for codes, constants and the sequencer state type.
//
// A user of the block should know the following first. One request is taken at
// a time; in_stall is high while a request is being worked on. A clear is done
// as it is accepted and never raises in_stall. A decoded newline passes through
// the result state. A decoded code bit is accepted with a read of the current
// node, then the node is tested and the child read, then the child is tested
// for a leaf; a missing branch ends at the first test. These steps are set by
// the one read port of the node store and its registered read data. A load does
// a counting walk along the existing nodes of the code, then a creating walk,
// with a store read per tree level and a write per new node. Results sit in an
// output register, so the next request is taken while a result still waits. The
// root node lives in flip-flops, so no clearing pass of the store is needed
// after reset or a clear: every other entry is written when its node is created.
module huffman_tree_decoder #(
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF,
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_symbol_in,
  input  logic [15:0] in_code_bits,
  input  logic [4:0]  in_code_length,
  input  logic [1:0]  in_char_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_decoded_symbol,
  output logic [1:0]  out_status
);

  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NW = IW + 1;
  localparam int EW = 2 * IW + 8;
  localparam int CW = (NW > 5) ? NW : 5;

  // node store: {left, right, symbol}; entry zero is unused, root is in flops
  logic [EW-1:0] node_mem [NODE_COUNT];
  logic [EW-1:0] mem_rdata_r;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  htd_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] root_left_r,  root_left_nxt;
  logic [IW-1:0] root_right_r, root_right_nxt;
  logic [7:0]    root_sym_r,   root_sym_nxt;
  logic [NW-1:0] next_free_r,  next_free_nxt;
  logic [IW-1:0] walk_r,       walk_nxt;
  logic [IW-1:0] node_r,       node_nxt;
  logic [IW-1:0] new_r,        new_nxt;
  logic [4:0]    idx_r,        idx_nxt;

  logic [7:0]    sym_r,        sym_nxt;
  logic [15:0]   bits_r,       bits_nxt;
  logic [4:0]    len_r,        len_nxt;
  logic [1:0]    kind_r,       kind_nxt;
  logic [7:0]    res_sym_r,    res_sym_nxt;
  logic [1:0]    res_status_r, res_status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_sym_r,   out_sym_nxt;
  logic [1:0]    out_st_r,    out_st_nxt;

  logic          out_load;
  logic [7:0]    out_load_sym;
  logic [1:0]    out_load_st;
  logic          slot_free;
  logic          in_take;

  // current node entry: root from flops, anything else from the read register
  logic [IW-1:0] cur_left, cur_right;
  logic [7:0]    cur_sym;
  logic          cur_is_root;
  logic [IW-1:0] rd_left, rd_right;
  logic [7:0]    rd_sym;
  logic [4:0]    pos;
  logic          code_b;
  logic [IW-1:0] child;
  logic [CW-1:0] need, room;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != htd_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;

  assign rd_left  = mem_rdata_r[EW-1 -: IW];
  assign rd_right = mem_rdata_r[IW+7 -: IW];
  assign rd_sym   = mem_rdata_r[7:0];

  assign cur_is_root = (state_r == htd_pkg::S_D_EV) ? (walk_r == '0) : (node_r == '0);
  assign cur_left    = cur_is_root ? root_left_r  : rd_left;
  assign cur_right   = cur_is_root ? root_right_r : rd_right;
  assign cur_sym     = cur_is_root ? root_sym_r   : rd_sym;

  // code position len-1-i; positions at or above 16 read as zero
  assign pos    = len_r - 5'd1 - idx_r;
  assign code_b = pos[4] ? 1'b0 : bits_r[pos[3:0]];
  assign child  = ((state_r == htd_pkg::S_D_EV) ? kind_r[0] : code_b) ? cur_left : cur_right;

  assign need = CW'(len_r - idx_r);
  assign room = CW'(NODE_COUNT) - CW'(next_free_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= node_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= htd_pkg::S_IDLE;
      root_left_r  <= '0;
      root_right_r <= '0;
      root_sym_r   <= htd_pkg::FILL_SYMBOL;
      next_free_r  <= NW'(1);
      walk_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_left_r  <= root_left_nxt;
      root_right_r <= root_right_nxt;
      root_sym_r   <= root_sym_nxt;
      next_free_r  <= next_free_nxt;
      walk_r       <= walk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    new_r        <= new_nxt;
    idx_r        <= idx_nxt;
    sym_r        <= sym_nxt;
    bits_r       <= bits_nxt;
    len_r        <= len_nxt;
    kind_r       <= kind_nxt;
    res_sym_r    <= res_sym_nxt;
    res_status_r <= res_status_nxt;
    out_sym_r    <= out_sym_nxt;
    out_st_r     <= out_st_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    root_left_nxt  = root_left_r;
    root_right_nxt = root_right_r;
    root_sym_nxt   = root_sym_r;
    next_free_nxt  = next_free_r;
    walk_nxt       = walk_r;
    node_nxt       = node_r;
    new_nxt        = new_r;
    idx_nxt        = idx_r;
    sym_nxt        = sym_r;
    bits_nxt       = bits_r;
    len_nxt        = len_r;
    kind_nxt       = kind_r;
    res_sym_nxt    = res_sym_r;
    res_status_nxt = res_status_r;
    mem_re         = 1'b0;
    mem_raddr      = node_r;
    mem_we         = 1'b0;
    mem_waddr      = node_r;
    mem_wdata      = mem_rdata_r;
    out_load       = 1'b0;
    out_load_sym   = 8'd0;
    out_load_st    = htd_pkg::ST_SYMBOL;

    unique case (state_r)
      htd_pkg::S_IDLE: begin
        if (in_take) begin
          sym_nxt  = in_symbol_in;
          bits_nxt = in_code_bits;
          len_nxt  = in_code_length;
          kind_nxt = in_char_kind;
          unique case (in_operation)
            htd_pkg::OP_CLEAR: begin
              root_left_nxt  = '0;
              root_right_nxt = '0;
              root_sym_nxt   = htd_pkg::FILL_SYMBOL;
              next_free_nxt  = NW'(1);
              walk_nxt       = '0;
            end
            htd_pkg::OP_LOAD: begin
              if ({1'b0, in_code_length} > 6'(MAX_CODE_LEN)) begin
                res_sym_nxt    = 8'd0;
                res_status_nxt = htd_pkg::ST_OVERFLOW;
                state_nxt      = htd_pkg::S_EMIT;
              end else begin
                node_nxt  = '0;
                idx_nxt   = '0;
                state_nxt = htd_pkg::S_L1_RD;
              end
            end
            htd_pkg::OP_DECODE: begin
              case (in_char_kind) inside
                htd_pkg::KIND_ZERO, htd_pkg::KIND_ONE: begin
                  mem_re    = 1'b1;
                  mem_raddr = walk_r;
                  state_nxt = htd_pkg::S_D_EV;
                end
                htd_pkg::KIND_NEWLINE: begin
                  res_sym_nxt    = htd_pkg::NEWLINE_BYTE;
                  res_status_nxt = htd_pkg::ST_SYMBOL;
                  state_nxt      = htd_pkg::S_EMIT;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end

      htd_pkg::S_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_load_sym = res_sym_r;
          out_load_st  = res_status_r;
          state_nxt    = htd_pkg::S_IDLE;
        end
      end

      htd_pkg::S_D_EV: begin
        if (child == '0) begin
          if (slot_free) begin
            out_load    = 1'b1;
            out_load_st = htd_pkg::ST_MISSING;
            walk_nxt    = '0;
            state_nxt   = htd_pkg::S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = child;
          node_nxt  = child;
          state_nxt = htd_pkg::S_D_LF;
        end
      end

      htd_pkg::S_D_LF: begin
        if (rd_left == '0 && rd_right == '0) begin
          // leaf: emit and return to the root
          if (slot_free) begin
            out_load     = 1'b1;
            out_load_sym = rd_sym;
            walk_nxt     = '0;
            state_nxt    = htd_pkg::S_IDLE;
          end
        end else begin
          walk_nxt  = node_r;
          state_nxt = htd_pkg::S_IDLE;
        end
      end

      htd_pkg::S_L1_RD: begin
        mem_re    = 1'b1;
        mem_raddr = node_r;
        state_nxt = htd_pkg::S_L1_EV;
      end

      htd_pkg::S_L1_EV: begin
        // counting walk: follow existing nodes, then check the room left
        if (idx_r == len_r) begin
          node_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = htd_pkg::S_L2_RD;
        end else if (child != '0) begin
          node_nxt  = child;
          idx_nxt   = idx_r + 5'd1;
          state_nxt = htd_pkg::S_L1_RD;
        end else if (need <= room) begin
          node_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = htd_pkg::S_L2_RD;
        end else begin
          res_sym_nxt    = 8'd0;
          res_status_nxt = htd_pkg::ST_OVERFLOW;
          state_nxt      = htd_pkg::S_EMIT;
        end
      end

      htd_pkg::S_L2_RD: begin
        mem_re    = 1'b1;
        mem_raddr = node_r;
        state_nxt = htd_pkg::S_L2_EV;
      end

      htd_pkg::S_L2_EV: begin
        if (idx_r == len_r) begin
          if (node_r == '0) begin
            root_sym_nxt = sym_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = node_r;
            mem_wdata = {cur_left, cur_right, sym_r};
          end
          state_nxt = htd_pkg::S_IDLE;
        end else if (child != '0) begin
          node_nxt  = child;
          idx_nxt   = idx_r + 5'd1;
          state_nxt = htd_pkg::S_L2_RD;
        end else begin
          // hook the new node onto its parent, write the node itself next cycle
          new_nxt       = next_free_r[IW-1:0];
          next_free_nxt = next_free_r + NW'(1);
          if (node_r == '0) begin
            if (code_b) begin
              root_left_nxt = next_free_r[IW-1:0];
            end else begin
              root_right_nxt = next_free_r[IW-1:0];
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = node_r;
            mem_wdata = code_b ? {next_free_r[IW-1:0], cur_right, cur_sym}
                               : {cur_left, next_free_r[IW-1:0], cur_sym};
          end
          state_nxt = htd_pkg::S_L2_NEW;
        end
      end

      htd_pkg::S_L2_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = new_r;
        mem_wdata = {{(2 * IW){1'b0}}, htd_pkg::FILL_SYMBOL};
        node_nxt  = new_r;
        idx_nxt   = idx_r + 5'd1;
        state_nxt = htd_pkg::S_L2_RD;
      end

      default: state_nxt = htd_pkg::S_IDLE;
    endcase
  end

  // output register: load on a new result, hold while stalled
  always_comb begin
    out_sym_nxt = out_sym_r;
    out_st_nxt  = out_st_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = out_load_sym;
      out_st_nxt    = out_load_st;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_status         = out_st_r;

endmodule
